### hw/rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants for the indexed min-heap
// Operation and status codes, payload structs and default sizes.
// ----------------------------------------------------------------------------
package imh_pkg;

	localparam int DefCapacity  = 256;
	localparam int DefKeyWidth  = 31;
	localparam int VertexWidth  = 8;
	localparam int NumVertices  = 256;
	localparam int KeyPortWidth = 31;
	localparam int CountWidth   = 9;

	typedef enum logic [1:0] {
		OP_APPEND  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_SETKEY  = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]              op;
		logic [VertexWidth-1:0]  vertex;
		logic [KeyPortWidth-1:0] key_in;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [VertexWidth-1:0]  vertex_out;
		logic [KeyPortWidth-1:0] key_out;
		logic                    in_heap;
		logic [CountWidth-1:0]   count_out;
	} out_beat_t;

endpackage

### hw/rtl/imh_posmap.sv
// ----------------------------------------------------------------------------
// imh_posmap: vertex position map
// Synchronous memory of slot positions, one entry per vertex, with valid bits
// so that the heap can read a vertex never inserted as position CAPACITY.
// ----------------------------------------------------------------------------
module imh_posmap import imh_pkg::*; #(
	parameter int PW = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [VertexWidth-1:0] rd_addr,
	output logic [PW-1:0]          rd_data,
	output logic                   rd_valid,
	input  logic                   wr_en,
	input  logic [VertexWidth-1:0] wr_addr,
	input  logic [PW-1:0]          wr_data
);

	logic [PW-1:0]          mem [NumVertices];
	logic [NumVertices-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid <= vld_q[rd_addr];
			end
		end
	end

endmodule

### hw/rtl/imh_slots.sv
// ----------------------------------------------------------------------------
// imh_slots: heap slot memory
// One synchronous memory holding vertex and key of each heap slot.
// ----------------------------------------------------------------------------
module imh_slots import imh_pkg::*; #(
	parameter int AW = 8,
	parameter int DW = 39
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/indexed_min_heap_decrease_key.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key: indexed binary min-heap with decrease-key
// Append, query and set-key read the position map, then the slot it names;
// set-key then sifts the entry up one level at a time. Extract reads the root
// and the last entry, then sifts down one level at a time; on an empty heap it
// goes straight to the result. The slots have a single read port.
// Throughput: one beat in flight; the next beat is taken the cycle after the
// result is registered. Reset clears count and position valid bits, no sweep.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key import imh_pkg::*; #(
	parameter int CAPACITY  = DefCapacity,
	parameter int KEY_WIDTH = DefKeyWidth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int DW = VertexWidth + KEY_WIDTH;
	localparam int CW = AW + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_PRD, S_PCHK, S_SRD,
		S_XRD, S_XLAST, S_XL2,
		S_DN_L, S_DN_R, S_DN_CMP,
		S_UP_P, S_UP_CMP, S_FIN, S_DONE
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic [VertexWidth-1:0]  v_q;
	logic [KEY_WIDTH-1:0]    k_q;
	logic [PW-1:0]           cnt_q;
	logic [AW-1:0]           i_q;     // hole: slot that the moving entry will fill
	logic [DW-1:0]           cur_q;   // moving entry {vertex, key}
	logic [DW-1:0]           lch_q;   // extracted root, then left child
	logic [PW-1:0]           pos_q;
	status_t                 st_q;
	logic [VertexWidth-1:0]  vo_q;
	logic [KeyPortWidth-1:0] ko_q;
	logic                    hit_q;
	out_beat_t               res_q;
	logic                    rv_q;

	// memory ports
	logic          s_rd_en, s_wr_en;
	logic [AW-1:0] s_rd_addr, s_wr_addr;
	logic [DW-1:0] s_rd_data, s_wr_data;
	logic          p_rd_en, p_wr_en, p_vld;
	logic [VertexWidth-1:0] p_rd_addr, p_wr_addr;
	logic [PW-1:0] p_rd_data, p_wr_data;

	imh_slots #(.AW(AW), .DW(DW)) u_slots (
		.clk, .rd_en(s_rd_en), .rd_addr(s_rd_addr), .rd_data(s_rd_data),
		.wr_en(s_wr_en), .wr_addr(s_wr_addr), .wr_data(s_wr_data)
	);

	imh_posmap #(.PW(PW)) u_pos (
		.clk, .arst_n, .rd_en(p_rd_en), .rd_addr(p_rd_addr), .rd_data(p_rd_data),
		.rd_valid(p_vld), .wr_en(p_wr_en), .wr_addr(p_wr_addr), .wr_data(p_wr_data)
	);

	logic [PW-1:0]        pos_eff, last_w;
	logic [CW-1:0]        lidx_w, ridx_w, cnt_ext, dn_idx;
	logic [AW-1:0]        par_w;
	logic [KEY_WIDTH-1:0] cur_key, rd_key, l_key, best_key;
	logic [DW-1:0]        dn_ent;
	logic                 l_in, r_in, l_lt, r_lt, dn_move, up_move;
	logic                 pres, app_ok, done_go;

	// a vertex never written reads as position CAPACITY (absent)
	assign pos_eff   = p_vld ? p_rd_data : PW'(CAPACITY);
	assign last_w    = cnt_q - PW'(1);
	assign cnt_ext   = CW'(cnt_q);
	assign lidx_w    = {1'b0, i_q, 1'b1};
	assign ridx_w    = lidx_w + CW'(1);
	assign l_in      = lidx_w < cnt_ext;
	assign r_in      = ridx_w < cnt_ext;
	assign par_w     = (i_q - AW'(1)) >> 1;
	assign cur_key   = cur_q[KEY_WIDTH-1:0];
	assign rd_key    = s_rd_data[KEY_WIDTH-1:0];
	assign l_key     = lch_q[KEY_WIDTH-1:0];

	// sift-down pick: parent wins ties, then the left child
	assign l_lt      = l_key < cur_key;
	assign best_key  = l_lt ? l_key : cur_key;
	assign r_lt      = r_in && (rd_key < best_key);
	assign dn_move   = l_lt || r_lt;
	assign dn_ent    = r_lt ? s_rd_data : lch_q;
	assign dn_idx    = r_lt ? ridx_w : lidx_w;

	// sift-up moves only on a strictly smaller key
	assign up_move   = cur_key < rd_key;

	// membership: position below the count and the slot holds the vertex
	assign pres      = (pos_q < cnt_q) && (s_rd_data[DW-1:KEY_WIDTH] == v_q);
	assign app_ok    = (cnt_q < PW'(CAPACITY)) && !pres;

	// hold the result until the previous one has drained
	assign done_go   = (state_q == S_DONE) && (!rv_q || out_ready);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = rv_q;
	assign out_data  = res_q;

	// memory control, decoded from state; one access per port and cycle
	always_comb begin
		s_rd_en   = 1'b0;
		s_rd_addr = '0;
		s_wr_en   = 1'b0;
		s_wr_addr = i_q;
		s_wr_data = cur_q;
		p_rd_en   = 1'b0;
		p_rd_addr = v_q;
		p_wr_en   = 1'b0;
		p_wr_addr = cur_q[DW-1:KEY_WIDTH];
		p_wr_data = PW'(i_q);
		case (state_q)
			S_PRD: begin
				p_rd_en = 1'b1;
			end
			S_PCHK: begin
				s_rd_en   = 1'b1;
				s_rd_addr = AW'(pos_eff);
			end
			S_SRD: begin
				// append: new entry goes to the end, no sift
				if (op_q == OP_APPEND && app_ok) begin
					s_wr_en   = 1'b1;
					s_wr_addr = AW'(cnt_q);
					s_wr_data = {v_q, k_q};
					p_wr_en   = 1'b1;
					p_wr_addr = v_q;
					p_wr_data = cnt_q;
				end
			end
			S_XRD: begin
				s_rd_en   = 1'b1;
				s_rd_addr = '0;
			end
			S_XLAST: begin
				s_rd_en   = 1'b1;
				s_rd_addr = AW'(last_w);
			end
			S_XL2: begin
				// park the extracted root in the last slot
				s_wr_en   = 1'b1;
				s_wr_addr = AW'(last_w);
				s_wr_data = lch_q;
				p_wr_en   = 1'b1;
				p_wr_addr = lch_q[DW-1:KEY_WIDTH];
				p_wr_data = last_w;
			end
			S_DN_L: begin
				s_rd_en   = l_in;
				s_rd_addr = AW'(lidx_w);
			end
			S_DN_R: begin
				s_rd_en   = r_in;
				s_rd_addr = AW'(ridx_w);
			end
			S_DN_CMP: begin
				// pull the smaller child up into the hole
				if (dn_move) begin
					s_wr_en   = 1'b1;
					s_wr_data = dn_ent;
					p_wr_en   = 1'b1;
					p_wr_addr = dn_ent[DW-1:KEY_WIDTH];
				end
			end
			S_UP_P: begin
				s_rd_en   = (i_q != '0);
				s_rd_addr = par_w;
			end
			S_UP_CMP: begin
				// push the larger parent down into the hole
				if (up_move) begin
					s_wr_en   = 1'b1;
					s_wr_data = s_rd_data;
					p_wr_en   = 1'b1;
					p_wr_addr = s_rd_data[DW-1:KEY_WIDTH];
				end
			end
			S_FIN: begin
				// drop the moving entry into the hole
				s_wr_en = 1'b1;
				p_wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_APPEND;
			v_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			cur_q   <= '0;
			lch_q   <= '0;
			pos_q   <= '0;
			st_q    <= ST_OK;
			vo_q    <= '0;
			ko_q    <= '0;
			hit_q   <= 1'b0;
			res_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q  <= op_t'(in_data.op);
						v_q   <= in_data.vertex;
						k_q   <= KEY_WIDTH'(in_data.key_in);
						vo_q  <= in_data.vertex;
						ko_q  <= '0;
						hit_q <= 1'b0;
						if (op_t'(in_data.op) != OP_EXTRACT) begin
							st_q    <= ST_OK;
							state_q <= S_PRD;
						end else if (cnt_q == '0) begin
							st_q    <= ST_EMPTY;
							state_q <= S_DONE;
						end else begin
							st_q    <= ST_OK;
							state_q <= S_XRD;
						end
					end
				end
				S_PRD: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					pos_q   <= pos_eff;
					state_q <= S_SRD;
				end
				S_SRD: begin
					// slot data at pos_q valid now (membership check)
					case (op_q)
						OP_QUERY: begin
							hit_q   <= pres;
							state_q <= S_DONE;
						end
						OP_APPEND: begin
							if (!app_ok) begin
								st_q <= ST_FULL;
							end else begin
								cnt_q <= cnt_q + PW'(1);
							end
							state_q <= S_DONE;
						end
						OP_SETKEY: begin
							if (!pres) begin
								st_q    <= ST_ABSENT;
								state_q <= S_DONE;
							end else begin
								i_q     <= AW'(pos_q);
								cur_q   <= {v_q, k_q};
								state_q <= S_UP_P;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_XRD: begin
					state_q <= S_XLAST;
				end
				S_XLAST: begin
					// root arrives: report it while the last entry is read
					vo_q    <= s_rd_data[DW-1:KEY_WIDTH];
					ko_q    <= KeyPortWidth'(rd_key);
					lch_q   <= s_rd_data;
					state_q <= S_XL2;
				end
				S_XL2: begin
					// last entry becomes the moving entry, hole at the root
					cur_q   <= s_rd_data;
					cnt_q   <= last_w;
					i_q     <= '0;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					state_q <= l_in ? S_DN_R : S_FIN;
				end
				S_DN_R: begin
					lch_q   <= s_rd_data;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (dn_move) begin
						i_q     <= AW'(dn_idx);
						state_q <= S_DN_L;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_UP_P: begin
					state_q <= (i_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_move) begin
						i_q     <= par_w;
						state_q <= S_UP_P;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// advance the result into the output register once it is free
			if (done_go) begin
				res_q <= '{status: st_q, vertex_out: vo_q, key_out: ko_q,
					in_heap: hit_q, count_out: CountWidth'(cnt_q)};
				rv_q  <= 1'b1;
			end else if (out_ready) begin
				rv_q  <= 1'b0;
			end
		end
	end

endmodule

### verif/indexed_min_heap_decrease_key_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_checker: heap behavior checker
// Watches both channels, keeps its own copy of the heap, predicts each result
// and compares it field by field, counting mismatches.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_checker import imh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_beat_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_beat_t out_data,
	output int        fail_count,
	output int        pending
);

	localparam int Cap = DefCapacity;

	logic [7:0]  heap_vertex [Cap];
	logic [30:0] heap_key [Cap];
	int          vertex_slot [NumVertices];
	int          heap_size;
	out_beat_t   expected_q [$];

	function automatic bit holds(logic [7:0] v);
		int p;
		p = vertex_slot[v];
		return p < heap_size && heap_vertex[p] == v;
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [7:0]  tv;
		logic [30:0] tk;
		tv = heap_vertex[a];
		tk = heap_key[a];
		heap_vertex[a] = heap_vertex[b];
		heap_key[a] = heap_key[b];
		heap_vertex[b] = tv;
		heap_key[b] = tk;
		vertex_slot[heap_vertex[a]] = a;
		vertex_slot[heap_vertex[b]] = b;
	endfunction

	function automatic out_beat_t heap_apply(in_beat_t beat);
		out_beat_t r;
		int        i, best, l;
		r = '0;
		r.status = ST_OK;
		r.vertex_out = beat.vertex;
		case (op_t'(beat.op))
			OP_APPEND: begin
				if (heap_size >= Cap || holds(beat.vertex)) begin
					r.status = ST_FULL;
				end else begin
					heap_vertex[heap_size] = beat.vertex;
					heap_key[heap_size] = beat.key_in;
					vertex_slot[beat.vertex] = heap_size;
					heap_size++;
				end
			end
			OP_EXTRACT: begin
				if (heap_size == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.vertex_out = heap_vertex[0];
					r.key_out = heap_key[0];
					swap_slots(0, heap_size - 1);
					heap_size--;
					i = 0;
					forever begin
						best = i;
						l = 2 * i + 1;
						if (l < heap_size && heap_key[l] < heap_key[best])
							best = l;
						if (l + 1 < heap_size && heap_key[l + 1] < heap_key[best])
							best = l + 1;
						if (best == i)
							break;
						swap_slots(i, best);
						i = best;
					end
				end
			end
			OP_SETKEY: begin
				if (!holds(beat.vertex)) begin
					r.status = ST_ABSENT;
				end else begin
					i = vertex_slot[beat.vertex];
					heap_key[i] = beat.key_in;
					while (i > 0 && heap_key[i] < heap_key[(i - 1) / 2]) begin
						swap_slots(i, (i - 1) / 2);
						i = (i - 1) / 2;
					end
				end
			end
			default: r.in_heap = holds(beat.vertex);
		endcase
		r.count_out = CountWidth'(heap_size);
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		heap_size = 0;
		foreach (vertex_slot[v])
			vertex_slot[v] = Cap;
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && in_valid && in_ready)
			expected_q.push_back(heap_apply(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (out_data.status != want.status)
					report("status", out_data.status, want.status);
				if (out_data.vertex_out != want.vertex_out)
					report("vertex_out", out_data.vertex_out, want.vertex_out);
				if (out_data.key_out != want.key_out)
					report("key_out", out_data.key_out, want.key_out);
				if (out_data.in_heap != want.in_heap)
					report("in_heap", out_data.in_heap, want.in_heap);
				if (out_data.count_out != want.count_out)
					report("count_out", out_data.count_out, want.count_out);
			end
		end
		pending = expected_q.size();
	end

endmodule

### verif/indexed_min_heap_decrease_key_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_test: top-level test of the indexed min-heap
// Drives directed and random heap operations with random gaps on both sides;
// the checker predicts every result and the top gives the verdict.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_test;
	import imh_pkg::*;

	// Cycles without any beat before the run is abandoned.  It allows for the
	// slowest correct beat plus a long gap on each side.
	localparam int WatchLimit = 2000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;
	int        fail_count;
	int        pending;
	int        idle_cycles = 0;
	int        stall_left = 0;

	always #5 clk = ~clk;

	indexed_min_heap_decrease_key dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	indexed_min_heap_decrease_key_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Mostly short gaps, now and then a long one, and runs with none.
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one beat at the falling edge; hold it until accepted.
	// Valid drops only when a gap follows.
	task automatic send_beat(op_t op, logic [7:0] v, logic [30:0] k);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= {op, v, k};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Random key: wide spread, with extremes and a narrow range that force ties.
	function automatic logic [30:0] rand_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 31'($urandom_range(0, 7));
			default: return 31'($urandom());
		endcase
	endfunction

	// Stall the result side for random stretches, mostly short.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 30) begin
			out_ready <= 1'b0;
			stall_left <= gap_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: count cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int pick;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty heap, extremes, ties, absent and stale vertices.
		send_beat(OP_EXTRACT, 8'd9, 31'd0);
		send_beat(OP_SETKEY, 8'd0, 31'd1);
		send_beat(OP_QUERY, 8'd255, 31'd0);
		send_beat(OP_APPEND, 8'd0, '1);
		send_beat(OP_APPEND, 8'd255, 31'd0);
		send_beat(OP_APPEND, 8'd0, 31'd5);
		send_beat(OP_APPEND, 8'd7, 31'd5);
		send_beat(OP_APPEND, 8'd8, 31'd5);
		send_beat(OP_QUERY, 8'd0, 31'd0);
		send_beat(OP_SETKEY, 8'd8, 31'd0);
		send_beat(OP_SETKEY, 8'd0, 31'd1);
		send_beat(OP_SETKEY, 8'd7, '1);
		send_beat(OP_EXTRACT, 8'd0, 31'd0);
		send_beat(OP_QUERY, 8'd255, 31'd0);
		send_beat(OP_SETKEY, 8'd255, 31'd3);
		send_beat(OP_APPEND, 8'd255, 31'd2);
		repeat (5) send_beat(OP_EXTRACT, 8'd170, 31'd0);

		// Fill to capacity, hit full, then drain partly.
		for (int v = 0; v < 256; v++)
			send_beat(OP_APPEND, v[7:0], rand_key());
		send_beat(OP_APPEND, 8'd85, 31'd1);
		for (int n = 0; n < 120; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				send_beat(OP_SETKEY, 8'($urandom_range(0, 255)), rand_key());
			else
				send_beat(OP_EXTRACT, 8'($urandom()), 31'd0);
		end

		// Random mix leaning on valid sequences over a modest vertex set.
		for (int n = 0; n < 100; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				send_beat(OP_APPEND, 8'($urandom_range(0, 63)), rand_key());
			else if (pick < 60)
				send_beat(OP_EXTRACT, 8'($urandom()), 31'($urandom()));
			else if (pick < 85)
				send_beat(OP_SETKEY, 8'($urandom_range(0, 63)), rand_key());
			else
				send_beat(OP_QUERY, 8'($urandom()), 31'($urandom()));
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
hw/rtl/imh_pkg.sv
hw/rtl/imh_posmap.sv
hw/rtl/imh_slots.sv
hw/rtl/indexed_min_heap_decrease_key.sv
verif/indexed_min_heap_decrease_key_checker.sv
verif/indexed_min_heap_decrease_key_test.sv
